// ===== rtl/sfc_pkg.sv =====
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared widths, fixed-point shifts and register indexes of the sphere
// frustum cull block.
// ----------------------------------------------------------------------------
package sfc_pkg;

   localparam int FIELD_W     = 32;
   localparam int RADIUS_W    = 31;
   localparam int OWNER_W     = 16;
   localparam int AXIS_W      = 16;
   localparam int AXIS_FRAC   = 14;
   localparam int RATE_W      = 16;
   localparam int RATE_FRAC   = 12;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 64;
   localparam int NUM_STAGES  = 6;
   localparam int NUM_AXES    = 3;

   localparam logic [OWNER_W-1:0] HIDDEN_OWNER_RST = 16'hFFFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_CAMERA_XY    = 4'd0,
      REG_CAMERA_Z     = 4'd1,
      REG_RIGHT_AXIS   = 4'd2,
      REG_FORWARD_AXIS = 4'd3,
      REG_UP_AXIS      = 4'd4,
      REG_CLIP_LIMITS  = 4'd5,
      REG_VIEW_RATES   = 4'd6,
      REG_HIDDEN_OWNER = 4'd7
   } csr_index_type;

   localparam int AXIS_RIGHT   = 0;
   localparam int AXIS_FORWARD = 1;
   localparam int AXIS_UP      = 2;

endpackage

// ===== rtl/sfc_if.sv =====
// ----------------------------------------------------------------------------
// sfc_if
// Valid/ready channels of the sphere frustum cull block: object request,
// visibility response and register write.
// ----------------------------------------------------------------------------
interface sfc_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [sfc_pkg::FIELD_W-1:0]  obj_x;
   logic signed [sfc_pkg::FIELD_W-1:0]  obj_y;
   logic signed [sfc_pkg::FIELD_W-1:0]  obj_z;
   logic        [sfc_pkg::RADIUS_W-1:0] radius;
   logic        [sfc_pkg::OWNER_W-1:0]  owner_id;
   logic                                last_object;

   modport source (output valid, obj_x, obj_y, obj_z, radius, owner_id, last_object,
                   input ready);
   modport sink   (input valid, obj_x, obj_y, obj_z, radius, owner_id, last_object,
                   output ready);
endinterface

interface sfc_rsp_if;
   logic valid;
   logic ready;
   logic visible;
   logic hidden_by_owner;
   logic last_out;

   modport source (output valid, visible, hidden_by_owner, last_out, input ready);
   modport sink   (input valid, visible, hidden_by_owner, last_out, output ready);
endinterface

interface sfc_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [sfc_pkg::CSR_INDEX_W-1:0]       index;
   logic [sfc_pkg::CSR_DATA_W-1:0]        data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/sphere_frustum_cull_top.sv =====
// ----------------------------------------------------------------------------
// sphere_frustum_cull_top
// Bounding-sphere view-volume test: camera offset, axis projection, clip and
// side-plane checks in a six-stage pipeline.
// ----------------------------------------------------------------------------
// An object beat passes through the offset, product, projection, margin, rate
// and verdict registers in turn; sustained rate is one object per clock while
// the response side is ready, set by the fully pipelined projection multipliers
// (nine per object) and the two rate products, each split into a low and a high half.
// Each stage holds its beat while the stage after it is full and stalled, and
// empty stages fill behind a stalled output, so no beat is lost or repeated.
// Registers are written through the csr port, which is always ready; write
// them only while no object is in flight. hidden_by_owner is reported
// independently of the geometric tests.
// ----------------------------------------------------------------------------
module sphere_frustum_cull_top #(
   parameter int COORD_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   sfc_req_if.sink    req_if,
   sfc_rsp_if.source  rsp_if,
   sfc_csr_if.sink    csr_if
);

   localparam int CW  = (COORD_WIDTH < sfc_pkg::FIELD_W) ? COORD_WIDTH : sfc_pkg::FIELD_W;
   localparam int DW  = CW + 1;
   localparam int PW  = DW + sfc_pkg::AXIS_W;
   localparam int SW  = PW + 2;
   localparam int RW  = sfc_pkg::RADIUS_W + sfc_pkg::AXIS_FRAC + 1;
   localparam int GW  = ((SW > RW + 1) ? SW : RW + 1) + 2;
   localparam int MW  = GW + sfc_pkg::RATE_W + 1;
   localparam int LW  = GW / 2;
   localparam int HW  = GW - LW;
   localparam int LPW = LW + sfc_pkg::RATE_W;
   localparam int HPW = HW + sfc_pkg::RATE_W + 1;
   localparam int NS  = sfc_pkg::NUM_STAGES;
   localparam int NA  = sfc_pkg::NUM_AXES;

   // configuration
   logic signed [CW-1:0]                   cam_ff [NA];
   logic [NA*sfc_pkg::AXIS_W-1:0]          axis_ff [NA];
   logic [2*sfc_pkg::FIELD_W-1:0]          clip_ff;
   logic [2*sfc_pkg::RATE_W-1:0]           rates_ff;
   logic [sfc_pkg::OWNER_W-1:0]            hidden_ff;
   logic                                   csr_acc;

   assign csr_if.ready = 1'b1;
   assign csr_acc      = csr_if.valid && csr_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NA; i++) begin
            cam_ff[i]  <= '0;
            axis_ff[i] <= '0;
         end
         clip_ff   <= '0;
         rates_ff  <= '0;
         hidden_ff <= sfc_pkg::HIDDEN_OWNER_RST;
      end else if (csr_acc) begin
         case (csr_if.index)
            sfc_pkg::REG_CAMERA_XY: begin
               cam_ff[0] <= $signed(csr_if.data[CW-1:0]);
               cam_ff[1] <= $signed(csr_if.data[sfc_pkg::FIELD_W +: CW]);
            end
            sfc_pkg::REG_CAMERA_Z:     cam_ff[2] <= $signed(csr_if.data[CW-1:0]);
            sfc_pkg::REG_RIGHT_AXIS: begin
               axis_ff[sfc_pkg::AXIS_RIGHT] <= csr_if.data[NA*sfc_pkg::AXIS_W-1:0];
            end
            sfc_pkg::REG_FORWARD_AXIS: begin
               axis_ff[sfc_pkg::AXIS_FORWARD] <= csr_if.data[NA*sfc_pkg::AXIS_W-1:0];
            end
            sfc_pkg::REG_UP_AXIS: begin
               axis_ff[sfc_pkg::AXIS_UP] <= csr_if.data[NA*sfc_pkg::AXIS_W-1:0];
            end
            sfc_pkg::REG_CLIP_LIMITS:  clip_ff   <= csr_if.data;
            sfc_pkg::REG_VIEW_RATES:   rates_ff  <= csr_if.data[2*sfc_pkg::RATE_W-1:0];
            sfc_pkg::REG_HIDDEN_OWNER: hidden_ff <= csr_if.data[sfc_pkg::OWNER_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline flow
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] adv;

   always_comb begin
      adv[NS-1] = !vld_ff[NS-1] || rsp_if.ready;
      for (int k = NS-2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign req_if.ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= req_if.valid;
         for (int k = 1; k < NS; k++) begin
            if (adv[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // sideband carried along the pipe
   logic [sfc_pkg::RADIUS_W-1:0] rad_ff [NS-3];
   logic [NS-1:0]                hid_ff;
   logic [NS-1:0]                last_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         rad_ff[0]  <= req_if.radius;
         hid_ff[0]  <= (req_if.owner_id == hidden_ff);
         last_ff[0] <= req_if.last_object;
      end
      for (int k = 1; k < NS; k++) begin
         if (adv[k]) begin
            hid_ff[k]  <= hid_ff[k-1];
            last_ff[k] <= last_ff[k-1];
            if (k < NS-3) rad_ff[k] <= rad_ff[k-1];
         end
      end
   end

   // stage 0: offset from camera
   logic signed [DW-1:0] d_in [NA];
   logic signed [DW-1:0] d_ff [NA];

   always_comb begin
      d_in[0] = DW'($signed(req_if.obj_x[CW-1:0])) - DW'(cam_ff[0]);
      d_in[1] = DW'($signed(req_if.obj_y[CW-1:0])) - DW'(cam_ff[1]);
      d_in[2] = DW'($signed(req_if.obj_z[CW-1:0])) - DW'(cam_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) d_ff <= d_in;
   end

   // stage 1: component products
   logic signed [PW-1:0] prod_in [NA][NA];
   logic signed [PW-1:0] prod_ff [NA][NA];

   always_comb begin
      for (int a = 0; a < NA; a++) begin
         for (int c = 0; c < NA; c++) begin
            prod_in[a][c] = PW'(d_ff[c])
                          * PW'($signed(axis_ff[a][c*sfc_pkg::AXIS_W +: sfc_pkg::AXIS_W]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) prod_ff <= prod_in;
   end

   // stage 2: projections
   logic signed [SW-1:0] proj_in [NA];
   logic signed [SW-1:0] proj_ff [NA];

   always_comb begin
      for (int a = 0; a < NA; a++) begin
         proj_in[a] = SW'(prod_ff[a][0]) + SW'(prod_ff[a][1]) + SW'(prod_ff[a][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) proj_ff <= proj_in;
   end

   // stage 3: clip test, side margins
   logic signed [GW-1:0] r30, near30, far30, fwd, pr, pu, abs_r, abs_u;
   logic signed [GW-1:0] s_in, ar_in, au_in;
   logic                 fout_in;
   logic signed [GW-1:0] s_ff, ar_ff, au_ff;
   logic [4:3]           fout_ff;

   always_comb begin
      r30     = GW'($signed({1'b0, rad_ff[NS-4], {sfc_pkg::AXIS_FRAC{1'b0}}}));
      near30  = GW'($signed({clip_ff[sfc_pkg::FIELD_W-1:0], {sfc_pkg::AXIS_FRAC{1'b0}}}));
      far30   = GW'($signed({clip_ff[2*sfc_pkg::FIELD_W-1:sfc_pkg::FIELD_W],
                             {sfc_pkg::AXIS_FRAC{1'b0}}}));
      fwd     = GW'(proj_ff[sfc_pkg::AXIS_FORWARD]);
      pr      = GW'(proj_ff[sfc_pkg::AXIS_RIGHT]);
      pu      = GW'(proj_ff[sfc_pkg::AXIS_UP]);
      abs_r   = pr[GW-1] ? -pr : pr;
      abs_u   = pu[GW-1] ? -pu : pu;
      s_in    = fwd + r30;
      ar_in   = abs_r - r30;
      au_in   = abs_u - r30;
      fout_in = (fwd > far30 + r30) || (fwd < near30 - r30);
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s_ff       <= s_in;
         ar_ff      <= ar_in;
         au_ff      <= au_in;
         fout_ff[3] <= fout_in;
      end
   end

   // stage 4: rate scaling, low and high halves of the span
   logic [LPW-1:0]        phl_in, pvl_in, phl_ff, pvl_ff;
   logic signed [HPW-1:0] phh_in, pvh_in, phh_ff, pvh_ff;
   logic signed [MW-1:0]  ah_in, av_in, ah_ff, av_ff;

   always_comb begin
      phl_in = LPW'(s_ff[LW-1:0]) * LPW'(rates_ff[sfc_pkg::RATE_W-1:0]);
      pvl_in = LPW'(s_ff[LW-1:0])
             * LPW'(rates_ff[2*sfc_pkg::RATE_W-1:sfc_pkg::RATE_W]);
      phh_in = HPW'($signed(s_ff[GW-1:LW]))
             * HPW'($signed({1'b0, rates_ff[sfc_pkg::RATE_W-1:0]}));
      pvh_in = HPW'($signed(s_ff[GW-1:LW]))
             * HPW'($signed({1'b0, rates_ff[2*sfc_pkg::RATE_W-1:sfc_pkg::RATE_W]}));
      ah_in  = MW'(ar_ff) <<< sfc_pkg::RATE_FRAC;
      av_in  = MW'(au_ff) <<< sfc_pkg::RATE_FRAC;
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         phl_ff     <= phl_in;
         pvl_ff     <= pvl_in;
         phh_ff     <= phh_in;
         pvh_ff     <= pvh_in;
         ah_ff      <= ah_in;
         av_ff      <= av_in;
         fout_ff[4] <= fout_ff[3];
      end
   end

   // stage 5: verdict and output register
   logic signed [MW-1:0] ph_sum, pv_sum;
   logic                 vis_in;
   logic                 vis_ff;

   always_comb begin
      ph_sum = (MW'(phh_ff) <<< LW) + MW'($signed({1'b0, phl_ff}));
      pv_sum = (MW'(pvh_ff) <<< LW) + MW'($signed({1'b0, pvl_ff}));
      vis_in = !hid_ff[4] && !fout_ff[4] && !(ph_sum < ah_ff) && !(pv_sum < av_ff);
   end

   always_ff @(posedge clock) begin
      if (adv[5]) vis_ff <= vis_in;
   end

   assign rsp_if.valid           = vld_ff[NS-1];
   assign rsp_if.visible         = vis_ff;
   assign rsp_if.hidden_by_owner = hid_ff[NS-1];
   assign rsp_if.last_out        = last_ff[NS-1];

   // checks
   logic in_acc, out_acc;
   assign in_acc  = req_if.valid && req_if.ready;
   assign out_acc = rsp_if.valid && rsp_if.ready;

   a_owner_hides: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.hidden_by_owner |-> !rsp_if.visible)
      else $error("owner-hidden object reported visible");

   a_fill: assert property (@(posedge clock) disable iff (reset)
      in_acc && !out_acc |=> $countones(vld_ff) == $past($countones(vld_ff)) + 1)
      else $error("accepted beat not tracked in pipe");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      !in_acc && out_acc |=> $countones(vld_ff) + 1 == $past($countones(vld_ff)))
      else $error("delivered beat not retired from pipe");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      in_acc == out_acc |=> $countones(vld_ff) == $past($countones(vld_ff)))
      else $error("pipe occupancy changed without a beat");

endmodule
